// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/atcp_pkg.sv -----
package atcp_pkg;

  localparam int MAX_RING_ENTRIES = 1024;
  localparam int FRACTION_BITS    = 16;

  localparam int RAND_W     = 16;
  localparam int OFFSET_W   = 16;
  localparam int WIDTH_W    = 17;
  localparam int RING_W     = 11;
  localparam int PORT_IDX_W = 10;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [WIDTH_W-1:0] FRAC_ONE = WIDTH_W'(1) << FRACTION_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RING   = 2'd2;

  localparam logic OP_PICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [OFFSET_W-1:0] RESET_OFFSET = '0;
  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = FRAC_ONE;
  localparam logic [RING_W-1:0]   RESET_RING   = RING_W'(1024);

endpackage

// ----- design/aperture_two_choice_picker_top.sv -----
// Write item and error pick: result on out_valid the cycle after the accepting edge; one per cycle.
// Valid pick: a draw sequence on a shared multiplier, then two count reads on one RAM
// read port; the result is registered, and no new request is taken until it is out.
// Results cannot be stalled; out_valid is high for exactly one cycle per item.
// Reset (rst_n low, synchronous) restores the config and control registers and starts a clear
// pass over all MAX_RING_ENTRIES entries (1024 by default) to zero the counts; busy is high meanwhile.
`include "assert_macros.svh"

module aperture_two_choice_picker_top #(
  parameter int MAX_RING_ENTRIES = atcp_pkg::MAX_RING_ENTRIES,
  localparam int IDX_W = (MAX_RING_ENTRIES > 1) ? $clog2(MAX_RING_ENTRIES) : 1,
  localparam int RS_W  = $clog2(MAX_RING_ENTRIES + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [atcp_pkg::RAND_W-1:0]     in_rand_first,
  input  logic [atcp_pkg::RAND_W-1:0]     in_rand_second,
  input  logic [atcp_pkg::PORT_IDX_W-1:0] in_entry_index,
  input  logic [atcp_pkg::COUNT_W-1:0]    in_active_count,
  output logic                            out_valid,
  output logic [atcp_pkg::PORT_IDX_W-1:0] out_chosen_index,
  output logic [atcp_pkg::PORT_IDX_W-1:0] out_first_index,
  output logic [atcp_pkg::PORT_IDX_W-1:0] out_second_index,
  output logic                            out_pick_error,
  input  logic                            cfg_we,
  input  logic [atcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atcp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] T_CLEAR = 3'd0;
  localparam logic [2:0] T_IDLE  = 3'd1;
  localparam logic [2:0] T_DRAW  = 3'd2;
  localparam logic [2:0] T_RD2   = 3'd3;
  localparam logic [2:0] T_CMP   = 3'd4;

  localparam int PW = atcp_pkg::PORT_IDX_W;

  logic [2:0] state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;

  logic [atcp_pkg::OFFSET_W-1:0] offset_r;
  logic [atcp_pkg::WIDTH_W-1:0]  width_r;
  logic [atcp_pkg::RING_W-1:0]   ring_r;

  logic [RS_W-1:0] rs;
  logic            accept, is_write, is_pick, pick_err, idx_ok, go;

  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr, ram_raddr;
  logic [atcp_pkg::COUNT_W-1:0] ram_wdata, ram_rdata;
  logic [atcp_pkg::COUNT_W-1:0] cnt1_r, cnt1_nxt;

  logic             draw_done;
  logic [IDX_W-1:0] draw_first, draw_second;

  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] chosen_r, chosen_nxt, first_r, first_nxt, second_r, second_nxt;
  logic          err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= atcp_pkg::RESET_OFFSET;
      width_r  <= atcp_pkg::RESET_WIDTH;
      ring_r   <= atcp_pkg::RESET_RING;
    end else if (cfg_we) begin
      case (cfg_index)
        atcp_pkg::CFG_OFFSET: offset_r <= cfg_wdata[atcp_pkg::OFFSET_W-1:0];
        atcp_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[atcp_pkg::WIDTH_W-1:0];
        atcp_pkg::CFG_RING:   ring_r   <= cfg_wdata[atcp_pkg::RING_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign rs = (32'(ring_r) > MAX_RING_ENTRIES) ? RS_W'(MAX_RING_ENTRIES) : RS_W'(ring_r);

  assign busy     = (state_r != T_IDLE);
  assign accept   = start && !busy;
  assign is_write = (in_opcode == atcp_pkg::OP_WRITE);
  assign is_pick  = (in_opcode == atcp_pkg::OP_PICK);
  assign pick_err = (rs == '0) || (width_r > atcp_pkg::FRAC_ONE);
  assign idx_ok   = (32'(in_entry_index) < MAX_RING_ENTRIES);
  assign go       = accept && is_pick && !pick_err;

  assign ram_we    = (state_r == T_CLEAR) || (accept && is_write && idx_ok);
  assign ram_waddr = (state_r == T_CLEAR) ? clr_r : IDX_W'(in_entry_index);
  assign ram_wdata = (state_r == T_CLEAR) ? '0 : in_active_count;
  assign ram_raddr = (state_r == T_RD2) ? draw_second : draw_first;

  atcp_ram #(
    .WIDTH (atcp_pkg::COUNT_W),
    .DEPTH (MAX_RING_ENTRIES)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  atcp_draw #(
    .MAX_RING_ENTRIES (MAX_RING_ENTRIES)
  ) u_draw (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .rand_first  (in_rand_first),
    .rand_second (in_rand_second),
    .offset      (offset_r),
    .width       (width_r),
    .rs          (rs),
    .done        (draw_done),
    .first       (draw_first),
    .second      (draw_second)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt1_nxt      = cnt1_r;
    out_valid_nxt = 1'b0;
    chosen_nxt    = chosen_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    err_nxt       = err_r;
    case (state_r)
      T_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(MAX_RING_ENTRIES - 1)) begin
          state_nxt = T_IDLE;
        end
      end
      T_IDLE: begin
        if (accept) begin
          if (go) begin
            state_nxt = T_DRAW;
          end else begin
            out_valid_nxt = 1'b1;
            chosen_nxt    = '0;
            first_nxt     = '0;
            second_nxt    = '0;
            err_nxt       = is_pick;
          end
        end
      end
      T_DRAW: begin
        if (draw_done) begin
          state_nxt = T_RD2;
        end
      end
      T_RD2: begin
        cnt1_nxt  = ram_rdata;
        state_nxt = T_CMP;
      end
      T_CMP: begin
        out_valid_nxt = 1'b1;
        chosen_nxt    = (cnt1_r < ram_rdata) ? PW'(draw_first) : PW'(draw_second);
        first_nxt     = PW'(draw_first);
        second_nxt    = PW'(draw_second);
        err_nxt       = 1'b0;
        state_nxt     = T_IDLE;
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt1_r   <= cnt1_nxt;
    chosen_r <= chosen_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
    err_r    <= err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_index = chosen_r;
  assign out_first_index  = first_r;
  assign out_second_index = second_r;
  assign out_pick_error   = err_r;

  `ASSERT_NEXT(a_write_word, clk, rst_n, accept && is_write, out_valid && !out_pick_error && out_chosen_index == '0, "write word lost")
  `ASSERT_CLK(a_chosen_is_candidate, clk, rst_n, out_valid && !out_pick_error |-> out_chosen_index == out_first_index || out_chosen_index == out_second_index, "chosen not a candidate")
  `ASSERT_CLK(a_ram_write_idle, clk, rst_n, ram_we |-> state_r == T_CLEAR || state_r == T_IDLE, "count write during pick")

endmodule

// ----- design/atcp_ram.sv -----
module atcp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/atcp_draw.sv -----
`include "assert_macros.svh"

module atcp_draw #(
  parameter int MAX_RING_ENTRIES = atcp_pkg::MAX_RING_ENTRIES,
  localparam int IDX_W = (MAX_RING_ENTRIES > 1) ? $clog2(MAX_RING_ENTRIES) : 1,
  localparam int RS_W  = $clog2(MAX_RING_ENTRIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [atcp_pkg::RAND_W-1:0]   rand_first,
  input  logic [atcp_pkg::RAND_W-1:0]   rand_second,
  input  logic [atcp_pkg::OFFSET_W-1:0] offset,
  input  logic [atcp_pkg::WIDTH_W-1:0]  width,
  input  logic [RS_W-1:0]               rs,
  output logic                          done,
  output logic [IDX_W-1:0]              first,
  output logic [IDX_W-1:0]              second
);

  localparam int F      = atcp_pkg::FRACTION_BITS;
  localparam int POS_W  = RS_W + F + 1;
  localparam int PROD_W = POS_W + atcp_pkg::RAND_W;
  localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << F;

  localparam logic [3:0] D_IDLE  = 4'd0;
  localparam logic [3:0] D_MUL0  = 4'd1;
  localparam logic [3:0] D_MUL1  = 4'd2;
  localparam logic [3:0] D_FIRST = 4'd3;
  localparam logic [3:0] D_FB    = 4'd4;
  localparam logic [3:0] D_FE    = 4'd5;
  localparam logic [3:0] D_OV    = 4'd6;
  localparam logic [3:0] D_REM   = 4'd7;
  localparam logic [3:0] D_MUL2  = 4'd8;
  localparam logic [3:0] D_POS2  = 4'd9;
  localparam logic [3:0] D_ADJ   = 4'd10;
  localparam logic [3:0] D_SEC   = 4'd11;

  logic [3:0] d_state_r, d_state_nxt;
  logic       done_r, done_nxt;

  logic [atcp_pkg::RAND_W-1:0] r1_r, r1_nxt, r2_r, r2_nxt;
  logic [POS_W-1:0] o_r, o_nxt, w_r, w_nxt, ow_r, ow_nxt, p_r, p_nxt;
  logic [POS_W-1:0] fb_r, fb_nxt, fe_r, fe_nxt, lo_r, lo_nxt, ov_r, ov_nxt;
  logic [POS_W-1:0] rem_r, rem_nxt, thr_r, thr_nxt, pos_r, pos_nxt;
  logic [IDX_W-1:0] first_r, first_nxt, second_r, second_nxt;

  logic [POS_W-1:0]            total;
  logic [POS_W-1:0]            mul_a;
  logic [atcp_pkg::RAND_W-1:0] mul_b;
  logic [PROD_W-1:0]           prod;
  logic [POS_W-1:0]            mod_in, mod_out;

  assign total = POS_W'(rs) << F;

  // shared multiplier: first draw, then second draw
  assign mul_a = (d_state_r == D_MUL1) ? w_r : rem_r;
  assign mul_b = (d_state_r == D_MUL1) ? r1_r : r2_r;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // wrap once around the ring
  assign mod_in  = (d_state_r == D_FIRST) ? (o_r + p_r) : pos_r;
  assign mod_out = (mod_in >= total) ? (mod_in - total) : mod_in;

  always_comb begin
    logic [POS_W-1:0] fbx, fb_sum, hi;
    fbx         = POS_W'(first_r) << F;
    fb_sum      = fbx + total;
    hi          = (fe_r < ow_r) ? fe_r : ow_r;
    d_state_nxt = d_state_r;
    done_nxt    = 1'b0;
    r1_nxt      = r1_r;
    r2_nxt      = r2_r;
    o_nxt       = o_r;
    w_nxt       = w_r;
    ow_nxt      = ow_r;
    p_nxt       = p_r;
    fb_nxt      = fb_r;
    fe_nxt      = fe_r;
    lo_nxt      = lo_r;
    ov_nxt      = ov_r;
    rem_nxt     = rem_r;
    thr_nxt     = thr_r;
    pos_nxt     = pos_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    case (d_state_r)
      D_IDLE: begin
        if (go) begin
          r1_nxt      = rand_first;
          r2_nxt      = rand_second;
          d_state_nxt = D_MUL0;
        end
      end
      D_MUL0: begin
        o_nxt       = POS_W'(offset) * POS_W'(rs);
        w_nxt       = POS_W'(width) * POS_W'(rs);
        d_state_nxt = D_MUL1;
      end
      D_MUL1: begin
        p_nxt       = POS_W'(prod >> F);
        ow_nxt      = o_r + w_r;
        d_state_nxt = D_FIRST;
      end
      D_FIRST: begin
        first_nxt   = mod_out[F +: IDX_W];
        d_state_nxt = D_FB;
      end
      D_FB: begin
        fb_nxt      = (fb_sum < ow_r) ? fb_sum : fbx;
        d_state_nxt = D_FE;
      end
      D_FE: begin
        fe_nxt      = fb_r + ONE_POS;
        lo_nxt      = (fb_r > o_r) ? fb_r : o_r;
        d_state_nxt = D_OV;
      end
      D_OV: begin
        ov_nxt      = (hi > lo_r) ? (hi - lo_r) : '0;
        d_state_nxt = D_REM;
      end
      D_REM: begin
        rem_nxt     = (w_r > ov_r) ? (w_r - ov_r) : '0;
        thr_nxt     = fe_r - ov_r;
        d_state_nxt = D_MUL2;
      end
      D_MUL2: begin
        p_nxt       = POS_W'(prod >> F);
        d_state_nxt = D_POS2;
      end
      D_POS2: begin
        pos_nxt     = o_r + p_r;
        d_state_nxt = D_ADJ;
      end
      D_ADJ: begin
        // skip the span taken by the first entry
        pos_nxt     = (pos_r >= thr_r) ? (pos_r + ov_r) : pos_r;
        d_state_nxt = D_SEC;
      end
      D_SEC: begin
        second_nxt  = (rem_r == '0) ? first_r : mod_out[F +: IDX_W];
        done_nxt    = 1'b1;
        d_state_nxt = D_IDLE;
      end
      default: begin
        d_state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_state_r <= D_IDLE;
      done_r    <= 1'b0;
    end else begin
      d_state_r <= d_state_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r1_r     <= r1_nxt;
    r2_r     <= r2_nxt;
    o_r      <= o_nxt;
    w_r      <= w_nxt;
    ow_r     <= ow_nxt;
    p_r      <= p_nxt;
    fb_r     <= fb_nxt;
    fe_r     <= fe_nxt;
    lo_r     <= lo_nxt;
    ov_r     <= ov_nxt;
    rem_r    <= rem_nxt;
    thr_r    <= thr_nxt;
    pos_r    <= pos_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
  end

  assign done   = done_r;
  assign first  = first_r;
  assign second = second_r;

  `ASSERT_CLK(a_go_when_idle, clk, rst_n, go |-> d_state_r == D_IDLE, "draw started while busy")
  `ASSERT_NEXT(a_done_after_sec, clk, rst_n, d_state_r == D_SEC, done_r && d_state_r == D_IDLE, "draw done missing")

endmodule
